/* rtl/core/hdfr_pkg.sv */
// Shared constants for the HD44780 expander framer: opcodes, register
// indexes, reset values of the configuration registers and cursor bases.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdfr_pkg;

  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_CHAR    = 2'd1,
    OP_CURSOR  = 2'd2,
    OP_NUMBER  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_RS_MASK        = 2'd1,
    REG_ENABLE_MASK    = 2'd2,
    REG_BACKLIGHT_MASK = 2'd3
  } reg_index_e;

  localparam logic [6:0] DeviceAddressReset = 7'd39;
  localparam logic [3:0] RsMaskReset        = 4'd1;
  localparam logic [3:0] EnableMaskReset    = 4'd4;
  localparam logic [3:0] BacklightMaskReset = 4'd8;

  localparam logic [7:0] Row0Base = 8'h80;
  localparam logic [7:0] Row1Base = 8'hC0;
  localparam logic [3:0] NibMask  = 4'hF;
  localparam logic [3:0] AsciiDigitHigh = 4'h3;

  localparam int unsigned NumDigits = 10;
  localparam int unsigned ValueWidth = 32;

endpackage

`default_nettype wire

/* rtl/core/hd44780_i2c_expander_framer.sv */
// HD44780 4-bit framer for an I2C port expander; depends on hdfr_pkg.
// A command, character or cursor request shows its first frame in the cycle after
// acceptance; a number first runs 32 double-dabble steps and then drops its leading
// zeros before its first frame. Frames then follow one per
// cycle while the sink is ready, four per LCD byte. Throughput: one request at a time,
// tready high only while idle. Reset (rst_ni low, asynchronous) restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module hd44780_i2c_expander_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tdata: value[31:0], row[32], column[38:33], zero pad[39].
  input  wire logic [39:0] s_axis_tdata,
  // tuser: opcode[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  // Frame stream.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: address[6:0], frame[14:7], zero pad[15].
  output      logic [15:0] m_axis_tdata,
  output      logic        m_axis_tlast
);

  localparam int unsigned BcdWidth = 4 * hdfr_pkg::NumDigits;
  localparam int unsigned BitCntWidth = $clog2(hdfr_pkg::ValueWidth);
  localparam int unsigned DigCntWidth = $clog2(hdfr_pkg::NumDigits + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [6:0] dev_addr_q;
  logic [3:0] rs_mask_q, en_mask_q, bl_mask_q;

  logic [1:0] state_q, state_d;
  logic [1:0] fcnt_q, fcnt_d;
  logic       is_num_q, is_num_d;
  logic       is_data_q, is_data_d;
  logic [7:0] byte_q, byte_d;
  logic [hdfr_pkg::ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic [BitCntWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntWidth-1:0] ndig_q, ndig_d;

  logic [BcdWidth-1:0] bcd_adj;
  logic [7:0] cur_byte;
  logic [3:0] cur_nib;
  logic [7:0] frame_base;
  logic [7:0] frame;
  logic       last_frame;
  logic       in_fire, out_fire;
  logic [7:0] cursor_base;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= hdfr_pkg::DeviceAddressReset;
      rs_mask_q  <= hdfr_pkg::RsMaskReset;
      en_mask_q  <= hdfr_pkg::EnableMaskReset;
      bl_mask_q  <= hdfr_pkg::BacklightMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hdfr_pkg::REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i;
        hdfr_pkg::REG_RS_MASK:        rs_mask_q  <= cfg_data_i[3:0] & hdfr_pkg::NibMask;
        hdfr_pkg::REG_ENABLE_MASK:    en_mask_q  <= cfg_data_i[3:0] & hdfr_pkg::NibMask;
        hdfr_pkg::REG_BACKLIGHT_MASK: bl_mask_q  <= cfg_data_i[3:0] & hdfr_pkg::NibMask;
        default: ;
      endcase
    end
  end

  // Shared add-3 unit: every BCD digit of five or more gets three added
  // before the register shifts left by one bit.
  always_comb begin
    for (int i = 0; i < hdfr_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign cursor_base = s_axis_tdata[32] ? hdfr_pkg::Row1Base : hdfr_pkg::Row0Base;

  assign cur_byte = is_num_q ? {hdfr_pkg::AsciiDigitHigh, bcd_q[BcdWidth-1 -: 4]} : byte_q;
  assign cur_nib  = fcnt_q[1] ? cur_byte[3:0] : cur_byte[7:4];
  assign frame_base = {cur_nib, bl_mask_q | (is_data_q ? rs_mask_q : 4'd0)};
  assign frame = fcnt_q[0] ? (frame_base & ~{4'd0, en_mask_q})
                           : (frame_base | {4'd0, en_mask_q});
  assign last_frame = (fcnt_q == 2'd3) &&
                      (!is_num_q || (ndig_q == DigCntWidth'(1)));

  always_comb begin
    state_d   = state_q;
    fcnt_d    = fcnt_q;
    is_num_d  = is_num_q;
    is_data_d = is_data_q;
    byte_d    = byte_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          fcnt_d    = 2'd0;
          bin_d     = s_axis_tdata[31:0];
          bcd_d     = '0;
          bit_cnt_d = '0;
          ndig_d    = DigCntWidth'(hdfr_pkg::NumDigits);
          is_num_d  = 1'b0;
          unique case (s_axis_tuser)
            hdfr_pkg::OP_COMMAND: begin
              byte_d    = s_axis_tdata[7:0];
              is_data_d = 1'b0;
              state_d   = StEmit;
            end
            hdfr_pkg::OP_CHAR: begin
              byte_d    = s_axis_tdata[7:0];
              is_data_d = 1'b1;
              state_d   = StEmit;
            end
            hdfr_pkg::OP_CURSOR: begin
              byte_d    = 8'(cursor_base + {2'd0, s_axis_tdata[38:33]});
              is_data_d = 1'b0;
              state_d   = StEmit;
            end
            default: begin
              is_num_d  = 1'b1;
              is_data_d = 1'b1;
              state_d   = StConv;
            end
          endcase
        end
      end
      StConv: begin
        bcd_d     = {bcd_adj[BcdWidth-2:0], bin_q[hdfr_pkg::ValueWidth-1]};
        bin_d     = {bin_q[hdfr_pkg::ValueWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BitCntWidth'(1);
        if (bit_cnt_q == BitCntWidth'(hdfr_pkg::ValueWidth - 1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Leading zeros are dropped, but a zero value keeps its last digit.
        if ((bcd_q[BcdWidth-1 -: 4] == 4'd0) && (ndig_q != DigCntWidth'(1))) begin
          bcd_d  = {bcd_q[BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - DigCntWidth'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_fire) begin
          fcnt_d = fcnt_q + 2'd1;
          if (last_frame) begin
            state_d = StIdle;
          end else if (fcnt_q == 2'd3) begin
            bcd_d  = {bcd_q[BcdWidth-5:0], 4'd0};
            ndig_d = ndig_q - DigCntWidth'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      fcnt_q  <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_num_q  <= is_num_d;
    is_data_q <= is_data_d;
    byte_q    <= byte_d;
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StEmit);
  assign m_axis_tdata  = {1'b0, frame, dev_addr_q};
  assign m_axis_tlast  = last_frame;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for hd44780_i2c_expander_framer: random and directed LCD requests go in
// on the request stream, and each expander frame that comes out is checked against a prediction.
// Depends on hdfr_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_top;
  import hdfr_pkg::*;

  localparam int CycleLimit = 600000;

  typedef struct {
    opcode_e     op;
    logic [31:0] value;
    logic        row;
    logic [5:0]  column;
  } lcd_request_t;

  typedef struct {
    logic [6:0] address;
    logic [7:0] frame;
    logic       last;
  } expander_frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: value[31:0], row[32], column[38:33], zero pad[39].
  logic [39:0] s_axis_tdata = '0;
  // tuser: opcode[1:0].
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: address[6:0], frame[14:7], zero pad[15].
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  hd44780_i2c_expander_framer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Bench copy of the configuration registers.
  logic [6:0] dev_address = DeviceAddressReset;
  logic [3:0] rs_bits     = RsMaskReset;
  logic [3:0] en_bits     = EnableMaskReset;
  logic [3:0] bl_bits     = BacklightMaskReset;

  lcd_request_t    pending_requests[$];
  expander_frame_t expected_frames[$];
  lcd_request_t    offered_request;

  int src_idle_pct = 35;
  int snk_idle_pct = 35;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic sink_hold_req = 1'b0;
  logic sink_hold_done = 1'b0;
  int   sink_hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void push_frame(logic [7:0] f);
    expected_frames.push_back('{address: dev_address, frame: f, last: 1'b0});
  endfunction

  function automatic void push_nibble(logic [3:0] nib, logic is_data);
    logic [7:0] base;
    base = {nib, bl_bits | (is_data ? rs_bits : 4'h0)};
    push_frame(base | {4'h0, en_bits});
    // The clear frame drops every enable bit, even where rs or backlight share it.
    push_frame(base & ~{4'h0, en_bits});
  endfunction

  function automatic void push_lcd_byte(logic [7:0] b, logic is_data);
    push_nibble(b[7:4], is_data);
    push_nibble(b[3:0], is_data);
  endfunction

  function automatic void predict_frames(lcd_request_t req);
    logic [3:0]  digits[10];
    logic [31:0] rest;
    logic [7:0]  cursor;
    int n;
    case (req.op)
      OP_COMMAND: push_lcd_byte(req.value[7:0], 1'b0);
      OP_CHAR:    push_lcd_byte(req.value[7:0], 1'b1);
      OP_CURSOR: begin
        cursor = (req.row ? Row1Base : Row0Base) + {2'b00, req.column};
        push_lcd_byte(cursor, 1'b0);
      end
      default: begin
        n = 0;
        rest = req.value;
        if (rest == 0) begin
          digits[0] = 4'd0;
          n = 1;
        end
        while (rest > 0) begin
          digits[n] = 4'(rest % 10);
          rest = rest / 10;
          n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
          push_lcd_byte({AsciiDigitHigh, digits[i]}, 1'b1);
        end
      end
    endcase
    expected_frames[expected_frames.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin : request_driver
    lcd_request_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frames(offered_request);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = pending_requests.pop_front();
          offered_request <= nxt;
          s_axis_tvalid   <= 1'b1;
          s_axis_tdata    <= {1'b0, nxt.column, nxt.row, nxt.value};
          s_axis_tuser    <= nxt.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long sink hold-off, counted here in cycles; the monitor only reads it.
  always @(posedge clk_i) begin : sink_hold
    if (rst_ni) begin
      if (sink_hold_req && !sink_hold_done) begin
        sink_hold_left <= 300;
        sink_hold_done <= 1'b1;
      end else if (sink_hold_left > 0) begin
        sink_hold_left <= sink_hold_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin : frame_monitor
    expander_frame_t got;
    expander_frame_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.address = m_axis_tdata[6:0];
        got.frame   = m_axis_tdata[14:7];
        got.last    = m_axis_tlast;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected frame transaction, actual address %h frame %h last %b",
                   $time, got.address, got.frame, got.last);
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          if (got.address !== want.address) begin
            $display("%0t: address mismatch, expected %h actual %h",
                     $time, want.address, got.address);
            mismatch_count++;
          end
          if (got.frame !== want.frame) begin
            $display("%0t: frame mismatch, expected %h actual %h", $time, want.frame, got.frame);
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time, want.last, got.last);
            mismatch_count++;
          end
        end
      end
      if (sink_hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(reg_index_e idx, logic [6:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DEVICE_ADDRESS: dev_address = data;
      REG_RS_MASK:        rs_bits = data[3:0];
      REG_ENABLE_MASK:    en_bits = data[3:0];
      default:            bl_bits = data[3:0];
    endcase
  endtask

  task automatic write_all(logic [6:0] addr, logic [3:0] rs, logic [3:0] en, logic [3:0] bl);
    cfg_write(REG_DEVICE_ADDRESS, addr);
    cfg_write(REG_RS_MASK, {3'b000, rs});
    cfg_write(REG_ENABLE_MASK, {3'b000, en});
    cfg_write(REG_BACKLIGHT_MASK, {3'b000, bl});
  endtask

  task automatic queue_request(opcode_e op, logic [31:0] value, logic row, logic [5:0] column);
    pending_requests.push_back('{op: op, value: value, row: row, column: column});
  endtask

  // Blocks until every request has been taken and every predicted frame has arrived.
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int count);
    logic [31:0] value;
    opcode_e     op;
    for (int i = 0; i < count; i++) begin
      op = opcode_e'($urandom_range(0, 3));
      value = $urandom;
      // Numbers lean toward few digits, with some full-width values.
      if (op == OP_NUMBER) begin
        case ($urandom_range(0, 5))
          0: value = 32'd0;
          1: value = $urandom_range(0, 9);
          2: value = $urandom_range(0, 9999);
          3: value = $urandom_range(0, 99999999);
          4: value = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: value = $urandom;
        endcase
      end
      queue_request(op, value, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset register values.
    queue_request(OP_COMMAND, 32'h0000_0000, 1'b0, 6'd0);
    queue_request(OP_COMMAND, 32'h0000_00FF, 1'b1, 6'd63);
    queue_request(OP_COMMAND, 32'hFFFF_FF01, 1'b0, 6'd0);
    queue_request(OP_CHAR, 32'h0000_0041, 1'b0, 6'd0);
    queue_request(OP_CHAR, 32'hFFFF_FF5A, 1'b1, 6'd63);
    queue_request(OP_CHAR, 32'h0000_0000, 1'b0, 6'd0);
    queue_request(OP_CHAR, 32'h0000_00FF, 1'b0, 6'd0);
    queue_request(OP_CURSOR, 32'h0000_0000, 1'b0, 6'd0);
    queue_request(OP_CURSOR, 32'h0000_0000, 1'b1, 6'd0);
    queue_request(OP_CURSOR, 32'hFFFF_FFFF, 1'b0, 6'd63);
    queue_request(OP_CURSOR, 32'hA5A5_A5A5, 1'b1, 6'd63);
    queue_request(OP_CURSOR, 32'h0000_0000, 1'b1, 6'd21);
    queue_request(OP_NUMBER, 32'd0, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'd1, 1'b1, 6'd63);
    queue_request(OP_NUMBER, 32'd9, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'd10, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'd100, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'd999999999, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'd1000000000, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'hFFFF_FFFF, 1'b1, 6'd63);
    queue_request(OP_NUMBER, 32'd1234567890, 1'b0, 6'd0);
    queue_request(OP_NUMBER, 32'h8000_0000, 1'b0, 6'd0);
    wait_for_drain();

    // All registers at their low extreme, with no idling on either side.
    write_all(7'd0, 4'h0, 4'h0, 4'h0);
    src_idle_pct <= 0;
    snk_idle_pct <= 0;
    run_random_phase(80);

    // All registers at their high extreme; the sink holds off so the block backs up.
    write_all(7'd127, 4'hF, 4'hF, 4'hF);
    src_idle_pct <= 35;
    snk_idle_pct <= 35;
    sink_hold_req <= 1'b1;
    run_random_phase(80);

    // Masks that share bits with the enable strobe.
    write_all(7'h2A, 4'h5, 4'h6, 4'h3);
    run_random_phase(80);

    for (int p = 0; p < 2; p++) begin
      write_all(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      run_random_phase(80);
    end

    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* hd44780_i2c_expander_framer.f */
rtl/core/hdfr_pkg.sv
rtl/core/hd44780_i2c_expander_framer.sv
test/tb_top.sv
